@@ sv/rbnu_pkg.sv @@
// ============================================================================
// rbnu_pkg
// Shared types and constants for the row buffer with next-use replacement.
// ============================================================================
`default_nettype none

package rbnu_pkg;

    localparam int LINES_DEF   = 16;
    localparam int ROWS        = 64;
    localparam int ROW_NNZ     = 4;
    localparam int ROW_W       = 6;
    localparam int TAG_W       = 7;
    localparam int COL_W       = 16;
    localparam int DIST_W      = 16;
    localparam int NNZ_W       = 3;
    localparam int WAIT_W      = 8;
    localparam int LAT_RESET   = 10;

    localparam logic [TAG_W-1:0]  TAG_EMPTY = TAG_W'(ROWS);
    localparam logic [DIST_W-1:0] NO_USE    = {DIST_W{1'b1}};

    typedef enum logic [1:0] {
        STATUS_WAIT  = 2'd0,
        STATUS_HIT   = 2'd1,
        STATUS_FILL  = 2'd2,
        STATUS_DIST  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COUNT,
        ST_DECIDE,
        ST_NEXT,
        ST_VSCAN,
        ST_VWRITE,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

@@ sv/rbnu_ram.sv @@
// ============================================================================
// rbnu_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module rbnu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ sv/row_buffer_next_use_replacement_core.sv @@
// ============================================================================
// row_buffer_next_use_replacement_core
// Row-tagged line buffer; misses fill after a programmable wait and replace
// the line whose row has the largest next-use distance.
// ============================================================================
// Distance write: written on the transfer; the result passes through ST_OUT
// into the output register. Request: one line scan plus one further scan per
// filled line (each through the shared compare unit and the line and distance
// RAMs); one request in flight, ready only when the sequencer is idle.
// Reset: all lines empty, all distances 65535, wait count 0, latency LAT_RESET.
`default_nettype none

module row_buffer_next_use_replacement_core
    import rbnu_pkg::*;
#(
    parameter int LINES = LINES_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,

    input  wire logic         cfg_wr_en,
    input  wire logic [7:0]   cfg_wr_data,

    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // row, distance, nnz, col_a, col_b, col_c, col_d, val_a, val_b, val_c, val_d
    input  wire logic [223:0] s_axis_tdata,
    // kind
    input  wire logic         s_axis_tuser,

    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // lines_filled
    output logic [7:0]        m_axis_tdata,
    // status
    output logic [1:0]        m_axis_tuser
);

    localparam int IDX_W  = $clog2(LINES);
    localparam int CNT_W  = $clog2(LINES + 1);
    localparam int LINE_W = TAG_W + COL_W;

    state_t state_reg, state_next;

    logic [WAIT_W-1:0] lat_reg, lat_next;
    logic [WAIT_W-1:0] wait_reg, wait_next;

    logic [ROW_W-1:0]  row_reg, row_next;
    logic [NNZ_W-1:0]  nnz_reg, nnz_next;
    logic [COL_W-1:0]  cols_reg [ROW_NNZ];
    logic [COL_W-1:0]  cols_next [ROW_NNZ];
    logic [ROW_NNZ-1:0] found_reg, found_next;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [NNZ_W-1:0]  elem_reg, elem_next;
    logic [NNZ_W-1:0]  filled_reg, filled_next;
    logic [1:0]        res_status_reg, res_status_next;

    logic              issue_on_reg, issue_on_next;
    logic [IDX_W-1:0]  issue_idx_reg, issue_idx_next;
    logic              p1_vld_reg;
    logic [IDX_W-1:0]  p1_idx_reg;
    logic              p2_vld_reg;
    logic [IDX_W-1:0]  p2_idx_reg;
    logic [TAG_W-1:0]  p2_tag_reg;
    logic [COL_W-1:0]  p2_col_reg;

    logic [DIST_W-1:0] best_d_reg, best_d_next;
    logic [COL_W-1:0]  best_c_reg, best_c_next;
    logic [IDX_W-1:0]  victim_reg, victim_next;

    logic [LINES-1:0]  line_valid_reg, line_valid_next;
    logic [ROWS-1:0]   dist_valid_reg, dist_valid_next;

    logic              out_valid_reg, out_valid_next;
    logic [1:0]        out_status_reg, out_status_next;
    logic [NNZ_W-1:0]  out_filled_reg, out_filled_next;

    logic              line_we;
    logic [LINE_W-1:0] line_rdata;
    logic              dist_we;
    logic [DIST_W-1:0] dist_rdata;

    logic [TAG_W-1:0]  p1_tag;
    logic [COL_W-1:0]  p1_col;
    logic [DIST_W-1:0] p2_dist;
    logic              p2_last;
    logic              p2_same_row;
    logic              in_xfer;
    logic [NNZ_W-1:0]  in_nnz;
    logic [WAIT_W-1:0] wait_inc;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign in_nnz   = (s_axis_tdata[24:22] > NNZ_W'(ROW_NNZ)) ? NNZ_W'(ROW_NNZ)
                                                              : s_axis_tdata[24:22];
    assign wait_inc = wait_reg + WAIT_W'(1);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {5'b0, out_filled_reg};

    rbnu_ram #(
        .WIDTH (LINE_W),
        .DEPTH (LINES)
    ) u_line_ram (
        .clk   (clk),
        .we    (line_we),
        .waddr (victim_reg),
        .wdata ({TAG_W'(row_reg), cols_reg[elem_reg[1:0]]}),
        .raddr (issue_idx_reg),
        .rdata (line_rdata)
    );

    rbnu_ram #(
        .WIDTH (DIST_W),
        .DEPTH (ROWS)
    ) u_dist_ram (
        .clk   (clk),
        .we    (dist_we),
        .waddr (s_axis_tdata[5:0]),
        .wdata (s_axis_tdata[21:6]),
        .raddr (p1_tag[ROW_W-1:0]),
        .rdata (dist_rdata)
    );

    // empty lines read as their reset contents
    assign p1_tag = line_valid_reg[p1_idx_reg] ? line_rdata[LINE_W-1:COL_W] : TAG_EMPTY;
    assign p1_col = line_valid_reg[p1_idx_reg] ? line_rdata[COL_W-1:0] : COL_W'(p1_idx_reg);

    assign p2_dist = (p2_tag_reg >= TAG_EMPTY)          ? NO_USE :
                     dist_valid_reg[p2_tag_reg[ROW_W-1:0]] ? dist_rdata : NO_USE;
    assign p2_last     = p2_vld_reg && (p2_idx_reg == IDX_W'(LINES - 1));
    assign p2_same_row = (p2_tag_reg == TAG_W'(row_reg));

    always_comb
    begin
        state_next      = state_reg;
        lat_next        = lat_reg;
        wait_next       = wait_reg;
        row_next        = row_reg;
        nnz_next        = nnz_reg;
        cols_next       = cols_reg;
        found_next      = found_reg;
        count_next      = count_reg;
        elem_next       = elem_reg;
        filled_next     = filled_reg;
        res_status_next = res_status_reg;
        issue_on_next   = issue_on_reg;
        issue_idx_next  = issue_idx_reg;
        best_d_next     = best_d_reg;
        best_c_next     = best_c_reg;
        victim_next     = victim_reg;
        line_valid_next = line_valid_reg;
        dist_valid_next = dist_valid_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_filled_next = out_filled_reg;
        line_we         = 1'b0;
        dist_we         = 1'b0;

        if (cfg_wr_en)
        begin
            lat_next = cfg_wr_data;
        end

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (issue_on_reg)
        begin
            if (issue_idx_reg == IDX_W'(LINES - 1))
            begin
                issue_on_next = 1'b0;
            end
            else
            begin
                issue_idx_next = issue_idx_reg + IDX_W'(1);
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    row_next = s_axis_tdata[5:0];
                    nnz_next = in_nnz;
                    for (int i = 0; i < ROW_NNZ; i++)
                    begin
                        cols_next[i] = s_axis_tdata[25 + COL_W*i +: COL_W];
                    end
                    filled_next = '0;
                    if (s_axis_tuser)
                    begin
                        dist_we = 1'b1;
                        dist_valid_next[s_axis_tdata[5:0]] = 1'b1;
                        res_status_next = STATUS_DIST;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        found_next     = '0;
                        count_next     = '0;
                        issue_on_next  = 1'b1;
                        issue_idx_next = '0;
                        state_next     = ST_COUNT;
                    end
                end
            end
            ST_COUNT:
            begin
                if (p2_vld_reg && p2_same_row)
                begin
                    count_next = count_reg + CNT_W'(1);
                    for (int i = 0; i < ROW_NNZ; i++)
                    begin
                        if (p2_col_reg == cols_reg[i])
                        begin
                            found_next[i] = 1'b1;
                        end
                    end
                end
                if (p2_last)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (count_reg == CNT_W'(nnz_reg))
                begin
                    res_status_next = STATUS_HIT;
                    state_next      = ST_OUT;
                end
                else if (wait_inc != lat_reg)
                begin
                    wait_next       = wait_inc;
                    res_status_next = STATUS_WAIT;
                    state_next      = ST_OUT;
                end
                else
                begin
                    wait_next  = '0;
                    elem_next  = '0;
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                if (elem_reg < nnz_reg)
                begin
                    if (!found_reg[elem_reg[1:0]])
                    begin
                        best_d_next    = '0;
                        best_c_next    = '0;
                        victim_next    = '0;
                        issue_on_next  = 1'b1;
                        issue_idx_next = '0;
                        state_next     = ST_VSCAN;
                    end
                    else
                    begin
                        elem_next = elem_reg + NNZ_W'(1);
                    end
                end
                else
                begin
                    res_status_next = STATUS_FILL;
                    state_next      = ST_OUT;
                end
            end
            ST_VSCAN:
            begin
                if (p2_vld_reg && !p2_same_row)
                begin
                    if (p2_dist > best_d_reg)
                    begin
                        best_d_next = p2_dist;
                        best_c_next = p2_col_reg;
                        victim_next = p2_idx_reg;
                    end
                    else if (p2_dist == best_d_reg && p2_col_reg < best_c_reg)
                    begin
                        best_c_next = p2_col_reg;
                        victim_next = p2_idx_reg;
                    end
                end
                if (p2_last)
                begin
                    state_next = ST_VWRITE;
                end
            end
            ST_VWRITE:
            begin
                line_we = 1'b1;
                line_valid_next[victim_reg] = 1'b1;
                filled_next = filled_reg + NNZ_W'(1);
                elem_next   = elem_reg + NNZ_W'(1);
                state_next  = ST_NEXT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_filled_next = filled_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            lat_reg        <= WAIT_W'(LAT_RESET);
            wait_reg       <= '0;
            issue_on_reg   <= 1'b0;
            issue_idx_reg  <= '0;
            p1_vld_reg     <= 1'b0;
            p2_vld_reg     <= 1'b0;
            line_valid_reg <= '0;
            dist_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            lat_reg        <= lat_next;
            wait_reg       <= wait_next;
            issue_on_reg   <= issue_on_next;
            issue_idx_reg  <= issue_idx_next;
            p1_vld_reg     <= issue_on_reg;
            p2_vld_reg     <= p1_vld_reg;
            line_valid_reg <= line_valid_next;
            dist_valid_reg <= dist_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg        <= row_next;
        nnz_reg        <= nnz_next;
        cols_reg       <= cols_next;
        found_reg      <= found_next;
        count_reg      <= count_next;
        elem_reg       <= elem_next;
        filled_reg     <= filled_next;
        res_status_reg <= res_status_next;
        best_d_reg     <= best_d_next;
        best_c_reg     <= best_c_next;
        victim_reg     <= victim_next;
        out_status_reg <= out_status_next;
        out_filled_reg <= out_filled_next;
        p1_idx_reg     <= issue_idx_reg;
        p2_idx_reg     <= p1_idx_reg;
        p2_tag_reg     <= p1_tag;
        p2_col_reg     <= p1_col;
    end

    a_filled_only_on_fill: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_status_reg != STATUS_FILL) |-> out_filled_reg == '0)
        else $error("lines filled reported without a fill");

    a_filled_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_filled_reg <= NNZ_W'(ROW_NNZ))
        else $error("more lines filled than elements");

    a_victim_marked: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_VWRITE |=> line_valid_reg[$past(victim_reg)])
        else $error("replaced line not marked valid");

    a_wait_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DECIDE && state_next == ST_NEXT |=> wait_reg == '0)
        else $error("wait count not cleared on fill");

    a_scan_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !issue_on_reg && !p2_vld_reg)
        else $error("line scan running while idle");

endmodule

`default_nettype wire

@@ tb/sv/row_buffer_next_use_replacement_core_tb.sv @@
// ============================================================================
// row_buffer_next_use_replacement_core_tb
// Streams distance writes and row request ticks into the row buffer and
// checks status and fill count of every result transfer against a local
// model of the line buffer, the distance table and the miss counter. Runs
// through several fetch latencies with random stalls on both streams.
// ============================================================================
`default_nettype none

module row_buffer_next_use_replacement_core_tb;
    import rbnu_pkg::*;

    localparam int CYCLE_LIMIT = 800000;

    typedef struct {
        logic                   kind;
        logic [ROW_W-1:0]       row;
        logic [DIST_W-1:0]      next_dist;
        logic [NNZ_W-1:0]       nnz;
        logic [3:0][COL_W-1:0]  col;
        logic [3:0][31:0]       val;
    } row_item_t;

    typedef struct {
        status_t    status;
        logic [2:0] filled;
    } outcome_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic [7:0]   cfg_wr_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [223:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [7:0]   m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    // line buffer model
    logic [TAG_W-1:0]  buf_tag [LINES_DEF];
    logic [COL_W-1:0]  buf_col [LINES_DEF];
    logic [31:0]       buf_val [LINES_DEF];
    logic [DIST_W-1:0] row_dist [ROWS];
    logic [WAIT_W-1:0] miss_count;
    logic [7:0]        fetch_latency_q;

    row_item_t pending_items[$];
    outcome_t  expected_outcomes[$];
    row_item_t in_flight;
    outcome_t  want;

    int queued_items = 0;
    int accepted_items = 0;
    int mismatches = 0;
    int cycles = 0;
    bit calm = 1'b0;

    logic [ROW_W-1:0] hot_rows [6];
    logic [COL_W-1:0] row_cols [ROWS][4];
    logic [NNZ_W-1:0] row_nnz [ROWS];

    row_buffer_next_use_replacement_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    function automatic logic [223:0] pack_item(row_item_t it);
        logic [223:0] d;
        int i;
        d = '0;
        d[5:0]   = it.row;
        d[21:6]  = it.next_dist;
        d[24:22] = it.nnz;
        for (i = 0; i < 4; i++)
        begin
            d[25 + 16*i +: 16] = it.col[i];
            d[89 + 32*i +: 32] = it.val[i];
        end
        return d;
    endfunction

    function automatic outcome_t buffer_step(row_item_t it);
        outcome_t          o;
        int                n, cnt, i, j, victim;
        logic [DIST_W-1:0] best_d, d;
        logic [COL_W-1:0]  best_c;
        logic [3:0]        missing;
        o.status = STATUS_WAIT;
        o.filled = 3'd0;
        if (it.kind)
        begin
            row_dist[it.row] = it.next_dist;
            o.status = STATUS_DIST;
            return o;
        end
        n = (it.nnz > ROW_NNZ) ? ROW_NNZ : int'(it.nnz);
        cnt = 0;
        for (j = 0; j < LINES_DEF; j++)
            if (buf_tag[j] == TAG_W'(it.row))
                cnt++;
        if (cnt == n)
        begin
            o.status = STATUS_HIT;
            return o;
        end
        miss_count = miss_count + 1'b1;
        if (miss_count != fetch_latency_q)
            return o;
        miss_count = '0;
        // missing columns are decided before any line is replaced
        missing = '0;
        for (i = 0; i < n; i++)
        begin
            missing[i] = 1'b1;
            for (j = 0; j < LINES_DEF; j++)
                if (buf_tag[j] == TAG_W'(it.row) && buf_col[j] == it.col[i])
                    missing[i] = 1'b0;
        end
        for (i = 0; i < n; i++)
        begin
            if (!missing[i])
                continue;
            best_d = '0;
            best_c = '0;
            victim = 0;
            for (j = 0; j < LINES_DEF; j++)
            begin
                if (buf_tag[j] == TAG_W'(it.row))
                    continue;
                d = (buf_tag[j] >= TAG_W'(ROWS)) ? NO_USE : row_dist[buf_tag[j][ROW_W-1:0]];
                if (d > best_d)
                begin
                    best_d = d;
                    best_c = buf_col[j];
                    victim = j;
                end
                else if (d == best_d && buf_col[j] < best_c)
                begin
                    best_c = buf_col[j];
                    victim = j;
                end
            end
            buf_tag[victim] = TAG_W'(it.row);
            buf_col[victim] = it.col[i];
            buf_val[victim] = it.val[i];
            o.filled = o.filled + 3'd1;
        end
        o.status = STATUS_FILL;
        return o;
    endfunction

    function automatic bit stall_now();
        return !calm && ($urandom_range(99) < 20);
    endfunction

    // source side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_outcomes.insert(expected_outcomes.size(), buffer_step(in_flight));
                accepted_items++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_items.size() != 0 && !stall_now())
                begin
                    in_flight = pending_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pack_item(in_flight);
                    s_axis_tuser  <= in_flight.kind;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_outcomes.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected result transfer: status %0d lines_filled %0d",
                                 m_axis_tuser, m_axis_tdata);
                    mismatches++;
                end
                else
                begin
                    want = expected_outcomes.pop_front();
                    if (m_axis_tuser !== want.status || m_axis_tdata !== {5'd0, want.filled})
                    begin
                        if (mismatches < 10)
                            $display({"mismatch: status exp %0d got %0d, ",
                                      "lines_filled exp %0d got %0d"},
                                     want.status, m_axis_tuser, want.filled, m_axis_tdata);
                        mismatches++;
                    end
                end
            end
            m_axis_tready <= !stall_now();
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic add_distance(logic [ROW_W-1:0] r, logic [DIST_W-1:0] d);
        row_item_t it;
        it.kind      = 1'b1;
        it.row       = r;
        it.next_dist = d;
        it.nnz       = NNZ_W'($urandom_range(7));
        it.col       = {16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
        it.val       = {32'($urandom), 32'($urandom), 32'($urandom), 32'($urandom)};
        pending_items.insert(pending_items.size(), it);
        queued_items++;
    endtask

    task automatic add_request(logic [ROW_W-1:0] r, logic [NNZ_W-1:0] k,
                               logic [3:0][COL_W-1:0] c, logic [3:0][31:0] v, int ticks);
        row_item_t it;
        int t;
        it.kind      = 1'b0;
        it.row       = r;
        it.next_dist = DIST_W'($urandom);
        it.nnz       = k;
        it.col       = c;
        it.val       = v;
        for (t = 0; t < ticks; t++)
        begin
            pending_items.insert(pending_items.size(), it);
            queued_items++;
        end
    endtask

    function automatic logic [DIST_W-1:0] pick_distance();
        int p;
        p = $urandom_range(99);
        if (p < 25)
            return '0;
        if (p < 40)
            return NO_USE;
        return DIST_W'($urandom);
    endfunction

    function automatic logic [ROW_W-1:0] pick_row();
        if ($urandom_range(4) == 0)
            return ROW_W'($urandom_range(63));
        return hot_rows[$urandom_range(5)];
    endfunction

    function automatic void refresh_row(int r);
        int i;
        row_nnz[r] = ($urandom_range(9) == 0) ? 3'd0 : NNZ_W'($urandom_range(4, 1));
        for (i = 0; i < 4; i++)
            row_cols[r][i] = ($urandom_range(3) == 0) ? COL_W'($urandom_range(7))
                                                      : COL_W'($urandom);
    endfunction

    function automatic logic [ROW_W-1:0] row_absent();
        int r, j, k;
        bit used;
        r = $urandom_range(63);
        for (k = 0; k < ROWS; k++)
        begin
            used = 1'b0;
            for (j = 0; j < LINES_DEF; j++)
                if (buf_tag[j] == TAG_W'((r + k) % ROWS))
                    used = 1'b1;
            if (!used)
                return ROW_W'((r + k) % ROWS);
        end
        return ROW_W'(r);
    endfunction

    task automatic random_phase(int count, int lat);
        int start, p, t, n, hi;
        logic [ROW_W-1:0] r;
        logic [3:0][31:0] v;
        start = queued_items;
        hi = (lat < 8) ? lat : 8;
        while (queued_items - start < count)
        begin
            p = $urandom_range(99);
            v = {32'($urandom), 32'($urandom), 32'($urandom), 32'($urandom)};
            r = pick_row();
            if (p < 15)
                add_distance(r, pick_distance());
            else if (p < 80)
            begin
                if ($urandom_range(9) == 0)
                    refresh_row(r);
                add_request(r, row_nnz[r], {row_cols[r][3], row_cols[r][2],
                            row_cols[r][1], row_cols[r][0]}, v,
                            lat + 1 + $urandom_range(1));
            end
            else if (p < 90)
                add_request(ROW_W'($urandom_range(63)), NNZ_W'($urandom_range(7)),
                            {16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)},
                            v, $urandom_range(hi, 1));
            else
            begin
                // single-element ticks with a fresh column each: the row keeps growing
                n = lat + 1;
                for (t = 0; t < n; t++)
                    add_request(r, 3'd1, {48'd0, 16'($urandom)}, v, 1);
            end
        end
    endtask

    task automatic wait_drained(int settle);
        do
            @(posedge clk);
        while (accepted_items != queued_items || expected_outcomes.size() != 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic set_latency(logic [7:0] v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        fetch_latency_q = v;
    endtask

    initial
    begin
        int i;
        logic [ROW_W-1:0] r;
        for (i = 0; i < LINES_DEF; i++)
        begin
            buf_tag[i] = TAG_EMPTY;
            buf_col[i] = COL_W'(i);
            buf_val[i] = '0;
        end
        for (i = 0; i < ROWS; i++)
        begin
            row_dist[i] = NO_USE;
            refresh_row(i);
        end
        for (i = 0; i < 6; i++)
            hot_rows[i] = ROW_W'($urandom_range(63));
        miss_count = '0;
        fetch_latency_q = 8'(LAT_RESET);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, empty request, clamped count, duplicate columns
        set_latency(8'd1);
        add_distance(6'd0, 16'd0);
        add_distance(6'd63, NO_USE);
        add_request(6'd0, 3'd0, '0, '0, 1);
        add_request(6'd63, 3'd7, {16'd7, 16'd0, 16'hFFFF, 16'd0},
                    {32'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000}, 2);
        add_request(6'd0, 3'd1, {48'd0, 16'd5}, {96'd0, 32'd1}, 2);
        add_distance(6'd63, 16'd0);
        add_request(6'd10, 3'd4, {16'd2, 16'd1, 16'hFFFF, 16'hFFFF},
                    {32'($urandom), 32'($urandom), 32'($urandom), 32'($urandom)}, 2);
        add_request(6'd42, 3'd5, {16'd9, 16'd8, 16'd9, 16'd8},
                    {32'($urandom), 32'($urandom), 32'($urandom), 32'($urandom)}, 2);

        calm = 1'b1;
        random_phase(300, 1);
        wait_drained(8);
        calm = 1'b0;

        // longest wait, then leave the miss counter well above the next latency
        set_latency(8'd255);
        for (i = 0; i < 4; i++)
            add_distance(pick_row(), pick_distance());
        r = row_absent();
        add_request(r, 3'd3, {16'd0, 16'($urandom), 16'($urandom), 16'($urandom)},
                    {32'($urandom), 32'($urandom), 32'($urandom), 32'($urandom)}, 256);
        wait_drained(8);
        r = row_absent();
        add_request(r, 3'd2, {32'd0, 16'($urandom), 16'($urandom)},
                    {32'($urandom), 32'($urandom), 32'($urandom), 32'($urandom)}, 40);
        wait_drained(8);

        set_latency(8'd6);
        random_phase(350, 6);
        wait_drained(8);

        set_latency(8'd3);
        random_phase(350, 3);
        wait_drained(8);

        set_latency(8'd10);
        random_phase(150, 10);
        wait_drained(120);

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
